@@ rtl/sted_pkg.sv @@
// ----------------------------------------------------------------------------
// sted_pkg
// Shared types and constants of the sorted table engine: request and result
// payloads, operation codes, sequencer states and the per-cell control word.
// ----------------------------------------------------------------------------
package sted_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int MODE_W   = 3;
	localparam int KEY_W    = 32;
	localparam int INDEX_W  = 6;
	localparam int POS_W    = 8;
	localparam int ENTRY_W  = 32;
	localparam int LENGTH_W = 7;

	typedef enum logic [MODE_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_REMOVE_VAL = 3'd1,
		OP_REMOVE_AT  = 3'd2,
		OP_FIND       = 3'd3,
		OP_READ       = 3'd4,
		OP_CLEAR      = 3'd5
	} sted_op_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   value;
		logic [INDEX_W-1:0] index;
	} sted_req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [POS_W-1:0] position;
		logic [ENTRY_W-1:0]      entry;
		logic [LENGTH_W-1:0]     length;
	} sted_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} sted_state_t;

	// Control word broadcast to every cell of the chain.
	typedef struct packed {
		logic cmp;      // latch compare flags against the key
		logic ins;      // open a slot at the insertion point
		logic del_val;  // close the slot of the first equal entry
		logic del_idx;  // close the slot at the request index
	} sted_cell_ctrl_t;

endpackage

@@ rtl/sted_cell.sv @@
// ----------------------------------------------------------------------------
// sted_cell
// One slot of the sorted chain: holds an entry, compares it with the key and
// takes its neighbor's entry when the chain opens or closes a slot.
// ----------------------------------------------------------------------------
module sted_cell import sted_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int IDX_W       = 7,
	parameter int CELL_IDX    = 0
) (
	input  logic                   clk,
	input  sted_cell_ctrl_t        ctrl,
	input  logic                   valid,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [IDX_W-1:0]       del_idx,
	input  logic                   left_ge,
	input  logic [VALUE_WIDTH-1:0] left_v,
	input  logic [VALUE_WIDTH-1:0] right_v,
	output logic [VALUE_WIDTH-1:0] v,
	output logic                   ge,
	output logic                   eq
);

	logic [VALUE_WIDTH-1:0] v_q;
	logic                   ge_q;
	logic                   eq_q;
	logic                   at_or_after;

	assign at_or_after = (IDX_W'(CELL_IDX) >= del_idx);

	// An empty slot counts as greater than any key, so ge is monotonic.
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			ge_q <= !valid || (v_q >= key);
			eq_q <= valid && (v_q == key);
		end
	end

	// Insert and removal never come together; hold the entry otherwise.
	always_ff @(posedge clk) begin
		if (ctrl.ins && ge_q) begin
			v_q <= left_ge ? left_v : key;
		end else if ((ctrl.del_val && ge_q) || (ctrl.del_idx && at_or_after)) begin
			v_q <= right_v;
		end
	end

	assign v  = v_q;
	assign ge = ge_q;
	assign eq = eq_q;

endmodule

@@ rtl/sorted_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// sorted_table_engine_core
// Sorted table of unsigned values built as a chain of compare/shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req (mode, value, index) and raise start; the
//   transfer happens at a rising edge with start high and busy low. busy
//   rises the cycle after and stays high through the compare and apply states.
//   Result channel: rsp is valid for exactly one cycle, marked by done. The
//   receiver cannot stall it; take it in that cycle or lose it.
//   After a transfer the sequencer runs the compare state, then the apply
//   state, each acting on every cell of the chain at once; done is registered
//   from the apply state. No new request is taken until the apply state ends.
//   A new request may be transferred in the same cycle that done is high.
//   Reset (arst_n low) empties the table and drops any request in flight;
//   entry contents are not cleared, only the length, which marks them empty.
//   Modes: insert, remove by value, remove at index, find, read, clear.
//   Unused mode codes return ok=0 and leave the table as it is.
// ----------------------------------------------------------------------------
module sorted_table_engine_core import sted_pkg::*; #(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  sted_req_t req,
	output logic      done,
	output sted_rsp_t rsp
);

	// Count width holds DEPTH itself; index width addresses the cells.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IXW  = $clog2(DEPTH);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

	sted_state_t      state_q, state_d;
	sted_cell_ctrl_t  ctrl;
	sted_req_t        req_q;
	logic [CW-1:0]    count_q, count_d;
	sted_rsp_t        rsp_q, rsp_d;
	logic             done_q;
	logic             accept;

	logic [VALUE_WIDTH-1:0] key;
	logic [VALUE_WIDTH-1:0] cell_v [DEPTH];
	logic [DEPTH-1:0]       cell_ge;
	logic [DEPTH-1:0]       cell_eq;
	logic [DEPTH-1:0]       cell_valid;
	logic [DEPTH-1:0]       first;

	logic [CMPW-1:0]  idx_ext;
	logic             idx_ok;
	logic             full;
	logic             found;
	logic             any_first;
	logic [CW-1:0]    enc;
	logic [CW-1:0]    ins_pos;
	logic [POS_W-1:0] pos_p1;
	logic [VALUE_WIDTH-1:0] rd_v;

	assign accept  = start && !busy;
	assign key     = VALUE_WIDTH'(req_q.value);
	assign idx_ext = CMPW'(req_q.index);
	assign idx_ok  = idx_ext < CMPW'(count_q);
	assign full    = (count_q == CW'(DEPTH));

	// Hold the request for the whole pass.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		busy         = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				// Every cell latches its compare flags against the key.
				ctrl.cmp = 1'b1;
				state_d  = ST_APPLY;
			end
			ST_APPLY: begin
				// Open or close a slot only when the operation succeeds.
				ctrl.ins     = (req_q.mode == OP_INSERT) && !full;
				ctrl.del_val = (req_q.mode == OP_REMOVE_VAL) && found;
				ctrl.del_idx = (req_q.mode == OP_REMOVE_AT) && idx_ok;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- cell chain ----------------
	// Each cell gets its left neighbor's value and flag for inserts and its
	// right neighbor's value for removals; the ends are tied off.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   left_ge;
		logic [VALUE_WIDTH-1:0] left_v;
		logic [VALUE_WIDTH-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_ge = 1'b0;
			assign left_v  = '0;
		end else begin : g_mid
			assign left_ge = cell_ge[i-1];
			assign left_v  = cell_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_v[i];
		end else begin : g_inner
			assign right_v = cell_v[i+1];
		end

		assign cell_valid[i] = (CW'(i) < count_q);
		// Insertion point: the first slot whose entry is not below the key.
		assign first[i]      = cell_ge[i] && !left_ge;

		sted_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.IDX_W       (CMPW),
			.CELL_IDX    (i)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.valid   (cell_valid[i]),
			.key     (key),
			.del_idx (idx_ext),
			.left_ge (left_ge),
			.left_v  (left_v),
			.right_v (right_v),
			.v       (cell_v[i]),
			.ge      (cell_ge[i]),
			.eq      (cell_eq[i])
		);
	end

	// Encode the one-hot insertion point and gather the match flag.
	always_comb begin
		enc       = '0;
		any_first = 1'b0;
		found     = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first[i]) begin
				enc = enc | CW'(i);
			end
			any_first = any_first | first[i];
			found     = found | cell_eq[i];
		end
	end

	// With a full table of smaller entries the insertion point is the end.
	assign ins_pos = any_first ? enc : count_q;
	assign pos_p1  = POS_W'(ins_pos) + POS_W'(1);
	assign rd_v    = cell_v[IXW'(req_q.index)];

	// ---------------- result and length ----------------
	always_comb begin
		count_d = count_q;
		rsp_d   = '0;
		unique case (req_q.mode)
			OP_INSERT: begin
				if (!full) begin
					count_d  = count_q + CW'(1);
					rsp_d.ok = 1'b1;
				end
			end
			OP_REMOVE_VAL: begin
				if (found) begin
					count_d  = count_q - CW'(1);
					rsp_d.ok = 1'b1;
				end
			end
			OP_REMOVE_AT: begin
				if (idx_ok) begin
					count_d  = count_q - CW'(1);
					rsp_d.ok = 1'b1;
				end
			end
			OP_FIND: begin
				rsp_d.ok       = found;
				rsp_d.position = found ? pos_p1 : -pos_p1;
			end
			OP_READ: begin
				if (idx_ok) begin
					rsp_d.ok    = 1'b1;
					rsp_d.entry = ENTRY_W'(rd_v);
				end
			end
			OP_CLEAR: begin
				count_d  = '0;
				rsp_d.ok = 1'b1;
			end
			default: begin
			end
		endcase
		rsp_d.length = LENGTH_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_APPLY);
			if (state_q == ST_APPLY) begin
				count_q <= count_d;
			end
		end
	end

	// Result payload needs no reset; done qualifies it.
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ rtl/sted_checker.sv @@
// ----------------------------------------------------------------------------
// sted_checker
// Port-level checks of the sorted table engine: request/result timing and
// result payload consistency.
// ----------------------------------------------------------------------------
module sted_checker import sted_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input sted_req_t req,
	input logic      done,
	input sted_rsp_t rsp
);

	// Every transfer yields its result strobe after the compare and apply states.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after request");

	// No new request is taken while one is in flight.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy ##1 busy))
		else $error("busy dropped while a request was in flight");

	// A strobe lasts one cycle and comes with the engine free.
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && !$past(done)))
		else $error("result strobe overlaps work in flight");

	// A failed operation never returns an entry.
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.ok) |-> (rsp.entry == '0))
		else $error("entry returned on failed operation");

endmodule

bind sorted_table_engine_core sted_checker u_sted_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

@@ tb/sv/tb_sorted_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_table_engine_core
// Self-checking bench for the sorted table engine. A queue of requests feeds
// a clocked driver that honors start/busy and inserts random idle bursts. A
// shadow copy of the table predicts every result at the moment its request
// transfers, and a clocked monitor compares each done strobe, field by field,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sorted_table_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sted_pkg::*;

	localparam int TBL_DEPTH = DEPTH_DEF;

	// Mode codes the block does not define; it must answer them and ignore them.
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

	localparam int RANDOM_TARGET  = 880;
	localparam int TAIL_ITEMS     = 60;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 600;
	localparam int REPORT_CAP     = 10;

	typedef struct {
		sted_req_t   req;
		int unsigned gap;  // idle cycles to hold start low before this request
	} req_job_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	sted_req_t req    = '0;
	logic      busy;
	logic      done;
	sted_rsp_t rsp;

	// Shadow of the table contents and its length.
	logic [KEY_W-1:0] shadow_tbl [TBL_DEPTH];
	int unsigned      shadow_len = 0;

	req_job_t    req_backlog [$];
	sted_rsp_t   pending_results [$];

	int unsigned items_queued = 0;
	int unsigned xfer_count   = 0;
	int unsigned rsp_count    = 0;
	int unsigned error_count  = 0;
	int unsigned full_rejects = 0;
	int unsigned op_tally [8] = '{default: 0};

	// Stimulus shaping: idle bursts on or off, and the base of the key pool.
	bit               idle_on  = 1'b0;
	logic [KEY_W-1:0] key_base = '0;

	sorted_table_engine_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------------
	// Shadow table
	// ------------------------------------------------------------------------

	// Signed 1-based slot of the first equal entry, or minus the slot where the
	// key would go when it is absent.
	function automatic int find_slot(logic [KEY_W-1:0] key);
		for (int i = 0; i < int'(shadow_len); i++) begin
			if (shadow_tbl[i] > key)
				return -(i + 1);
			if (shadow_tbl[i] == key)
				return i + 1;
		end
		return -(int'(shadow_len) + 1);
	endfunction

	// Close the gap at slot k and shorten the table.
	function automatic void drop_entry(int k);
		for (int i = k; i + 1 < int'(shadow_len); i++)
			shadow_tbl[i] = shadow_tbl[i + 1];
		shadow_len--;
	endfunction

	// Apply one request to the shadow table and return the result it must give.
	function automatic sted_rsp_t apply_to_shadow(sted_req_t r);
		sted_rsp_t res;
		int        slot;
		int        k;
		res = '0;
		case (r.mode)
			OP_INSERT: begin
				if (shadow_len < TBL_DEPTH) begin
					slot = find_slot(r.value);
					k = (slot < 0 ? -slot : slot) - 1;
					for (int i = int'(shadow_len); i > k; i--)
						shadow_tbl[i] = shadow_tbl[i - 1];
					shadow_tbl[k] = r.value;
					shadow_len++;
					res.ok = 1'b1;
				end else begin
					full_rejects++;
				end
			end
			OP_REMOVE_VAL: begin
				slot = find_slot(r.value);
				if (slot >= 1) begin
					drop_entry(slot - 1);
					res.ok = 1'b1;
				end
			end
			OP_REMOVE_AT: begin
				if (r.index < shadow_len) begin
					drop_entry(int'(r.index));
					res.ok = 1'b1;
				end
			end
			OP_FIND: begin
				slot = find_slot(r.value);
				res.position = slot[POS_W-1:0];
				res.ok = (slot > 0);
			end
			OP_READ: begin
				if (r.index < shadow_len) begin
					res.entry = shadow_tbl[r.index];
					res.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				shadow_len = 0;
				res.ok = 1'b1;
			end
			default: ;  // spare codes leave everything as it is
		endcase
		res.length = shadow_len[LENGTH_W-1:0];
		return res;
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= REPORT_CAP)
			$display("ERROR at %0t ns: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic sted_req_t make_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] v,
		logic [INDEX_W-1:0] ix);
		sted_req_t r;
		r.mode  = m;
		r.value = v;
		r.index = ix;
		return r;
	endfunction

	// Half the keys come from a narrow pool so finds and removes hit, plus the
	// extremes and the full 32-bit range.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return key_base + $urandom_range(0, 15);
			5: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return '1;
					2:       return {1'b1, {(KEY_W-1){1'b0}}};
					default: return {1'b0, {(KEY_W-1){1'b1}}};
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Bias toward indexes a typical table reaches, but cover all 64.
	function automatic logic [INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 9) < 7)
			return INDEX_W'($urandom_range(0, 23));
		return INDEX_W'($urandom);
	endfunction

	function automatic void add_req(logic [MODE_W-1:0] m, logic [KEY_W-1:0] v,
		logic [INDEX_W-1:0] ix);
		req_job_t job;
		job.req = make_req(m, v, ix);
		job.gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		req_backlog.push_back(job);
		items_queued++;
	endfunction

	// Random mix of every operation, weighted toward growth so the table
	// spends time at mid lengths between the occasional clear.
	function automatic void mixed_burst(int n);
		int unsigned roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 34)
				add_req(OP_INSERT, pick_key(), pick_index());
			else if (roll < 50)
				add_req(OP_REMOVE_VAL, pick_key(), pick_index());
			else if (roll < 60)
				add_req(OP_REMOVE_AT, pick_key(), pick_index());
			else if (roll < 78)
				add_req(OP_FIND, pick_key(), pick_index());
			else if (roll < 95)
				add_req(OP_READ, pick_key(), pick_index());
			else if (roll < 97)
				add_req(OP_CLEAR, pick_key(), pick_index());
			else
				add_req(roll[0] ? MODE_SPARE_A : MODE_SPARE_B, pick_key(), pick_index());
		end
	endfunction

	// ------------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------------
	// Sample start/busy as they stood before the edge: a transfer happens when
	// start was high and busy was low. Predict the result right then, so the
	// shadow table moves in the same order as the block does. Then either hold
	// the current request (still waiting on busy), burn an idle cycle, or load
	// the next one. start and req get a single assignment per edge.
	always @(posedge clk or negedge arst_n) begin : req_driver
		req_job_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				pending_results.push_back(apply_to_shadow(req));
				op_tally[req.mode]++;
				xfer_count++;
			end
			if (!start || !busy) begin
				if (req_backlog.size() != 0 && req_backlog[0].gap != 0) begin
					// Idle cycle: drop start, scramble the payload so a block that
					// samples req without start shows up as a mismatch.
					req_backlog[0].gap = req_backlog[0].gap - 1;
					start <= 1'b0;
					req   <= make_req(MODE_W'($urandom), $urandom, INDEX_W'($urandom));
				end else if (req_backlog.size() != 0) begin
					nxt = req_backlog.pop_front();
					start <= 1'b1;
					req   <= nxt.req;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------------
	// done marks a one-cycle result that cannot be stalled. Match it against
	// the oldest prediction; a strobe with nothing waiting is an error too.
	always @(posedge clk) begin : rsp_monitor
		sted_rsp_t want;
		if (arst_n && done) begin
			rsp_count++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result with no request pending: ok=%0b pos=%0d entry=%h len=%0d",
					rsp.ok, rsp.position, rsp.entry, rsp.length));
			end else begin
				want = pending_results.pop_front();
				if (rsp.ok !== want.ok || rsp.position !== want.position ||
					rsp.entry !== want.entry || rsp.length !== want.length) begin
					flag_error($sformatf({"result %0d: expected ok=%0b pos=%0d entry=%h len=%0d,",
						" got ok=%0b pos=%0d entry=%h len=%0d"}, rsp_count,
						want.ok, want.position, want.entry, want.length,
						rsp.ok, rsp.position, rsp.entry, rsp.length));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when nothing transfers for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transfer in %0d cycles, %0d of %0d requests taken",
			WATCHDOG_LIMIT, xfer_count, items_queued);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of test
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned random_goal;

		// Directed: empty-table corner cases first.
		add_req(OP_FIND, '0, '0);                        // absent on empty: position -1
		add_req(OP_READ, '0, '0);                        // index beyond length
		add_req(OP_REMOVE_AT, '0, '0);                   // index beyond length
		add_req(OP_REMOVE_VAL, '1, '1);                  // absent value
		add_req(OP_CLEAR, '1, '1);                       // clear is always ok
		// Build a small table with duplicates at both ends of the key range.
		add_req(OP_INSERT, 32'h8000_0000, '0);
		add_req(OP_INSERT, '1, '1);
		add_req(OP_INSERT, '0, '0);
		add_req(OP_INSERT, '0, 6'd1);                    // duplicate goes first
		add_req(OP_INSERT, '1, 6'd2);
		add_req(OP_FIND, '0, '0);                        // found at 1
		add_req(OP_FIND, '1, '1);                        // first of two equal entries
		add_req(OP_FIND, 32'h0000_0001, '0);             // absent, middle
		add_req(OP_FIND, 32'hFFFF_FFFE, '0);             // absent, just below max
		add_req(OP_READ, '0, 6'd4);                      // last valid index
		add_req(OP_READ, '0, '1);                        // index 63, out of range
		add_req(OP_REMOVE_VAL, 32'h8000_0000, '0);
		add_req(OP_REMOVE_VAL, 32'h0000_0005, '0);       // absent value
		add_req(OP_REMOVE_AT, '1, '0);
		add_req(OP_REMOVE_AT, '0, '1);                   // out of range
		add_req(MODE_SPARE_A, '1, '1);                   // spare codes: ignored
		add_req(MODE_SPARE_B, '0, '0);
		add_req(OP_READ, '0, 6'd1);
		add_req(OP_CLEAR, '0, '0);
		add_req(OP_FIND, '1, '0);                        // after clear: -1

		// Random episodes, each with its own key pool and idle setting.
		random_goal = items_queued + RANDOM_TARGET;
		while (items_queued < random_goal) begin
			idle_on  = ($urandom_range(0, 3) != 0);
			key_base = $urandom;
			case ($urandom_range(0, 7))
				0: begin
					// Fill the table to the top, push past it, probe the far end.
					add_req(OP_CLEAR, pick_key(), pick_index());
					repeat (TBL_DEPTH)
						add_req(OP_INSERT, pick_key(), pick_index());
					add_req(OP_INSERT, '1, '1);
					add_req(OP_INSERT, '0, '0);
					add_req(OP_FIND, '1, '1);               // usually -65 when full
					add_req(OP_FIND, '0, '0);
					add_req(OP_READ, pick_key(), '1);
					add_req(OP_READ, pick_key(), '0);
					repeat (8) begin
						add_req(OP_FIND, pick_key(), pick_index());
						add_req(OP_READ, pick_key(), INDEX_W'($urandom));
					end
					add_req(OP_REMOVE_AT, pick_key(), '1);
					add_req(OP_READ, pick_key(), '1);
					add_req(OP_INSERT, pick_key(), pick_index());
				end
				1: begin
					// Shrink from the front and by value.
					repeat (24) begin
						if ($urandom_range(0, 1) != 0)
							add_req(OP_REMOVE_AT, pick_key(), INDEX_W'($urandom_range(0, 3)));
						else
							add_req(OP_REMOVE_VAL, pick_key(), pick_index());
					end
				end
				default: mixed_burst($urandom_range(20, 60));
			endcase
		end

		// Closing stretch runs back to back with no idling.
		idle_on  = 1'b0;
		key_base = $urandom;
		mixed_burst(TAIL_ITEMS);

		// Release reset at a clock edge, like every other input.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to transfer, then for its result.
		while (xfer_count != items_queued)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// Keep clocking for DRAIN_CYCLES to catch stray strobes.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_results.size()));

		$display("Covered %0d requests: insert %0d, remove-value %0d, remove-at %0d, find %0d,",
			xfer_count, op_tally[OP_INSERT], op_tally[OP_REMOVE_VAL], op_tally[OP_REMOVE_AT],
			op_tally[OP_FIND]);
		$display("  read %0d, clear %0d, spare codes %0d; %0d results seen, %0d full-table refusals",
			op_tally[OP_READ], op_tally[OP_CLEAR], op_tally[MODE_SPARE_A] + op_tally[MODE_SPARE_B],
			rsp_count, full_rejects);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
